### src/pte_pkg.sv
`timescale 1ns / 1ps

package pte_pkg;

    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int CFG_IDX_W = 1;

    // History depth is kept a power of two so the slot is the low bits of the report count
    localparam int HIST_AW    = 2;
    localparam int HIST_DEPTH = 1 << HIST_AW;

    // Sum of the history plus the doubled entry
    localparam int SUM_W = DATA_W + $clog2(HIST_DEPTH + 1);
    localparam logic [DATA_W-1:0] AVG_DIV = DATA_W'(HIST_DEPTH + 1);

    // Divide the sum n = hi * 2^32 + lo by the weight of five as
    // (hi + carry of hi + lo) * (2^32 - 1) / 5 plus a reciprocal multiply of
    // the low word of hi + lo; holds since 2^32 leaves a remainder of one by five
    localparam int AVG_SHIFT = DATA_W + 2;
    localparam logic [DATA_W-1:0] AVG_RECIP =
        DATA_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_DIV) - 64'd1) / 64'(AVG_DIV));
    localparam logic [DATA_W-1:0] AVG_WRAP_Q =
        DATA_W'(((64'd1 << DATA_W) - 64'd1) / 64'(AVG_DIV));

    localparam int PROD_W    = 2 * DATA_W;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_ORIG_EST    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_STEPS = CFG_IDX_W'(1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INIT     = 3'd0,
        FUNC_START    = 3'd1,
        FUNC_PROGRESS = 3'd2,
        FUNC_END      = 3'd3,
        FUNC_TIME     = 3'd4
    } func_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_req_t;

endpackage

### src/pte_if.sv
`timescale 1ns / 1ps

interface pte_in_if;
    import pte_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] now_ms;
    logic [DATA_W-1:0] completed_steps;

    modport source (output valid, output func, output now_ms, output completed_steps,
                    input ready);
    modport sink   (input valid, input func, input now_ms, input completed_steps,
                    output ready);
endinterface

interface pte_out_if;
    import pte_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] expected_total_ms;
    logic [DATA_W-1:0] elapsed_ms;
    logic [DATA_W-1:0] remaining_ms;
    logic [DATA_W-1:0] steps_done;
    logic              running;
    logic              finished;

    modport source (output valid, output expected_total_ms, output elapsed_ms,
                    output remaining_ms, output steps_done, output running,
                    output finished, input ready);
    modport sink   (input valid, input expected_total_ms, input elapsed_ms,
                    input remaining_ms, input steps_done, input running,
                    input finished, output ready);
endinterface

### src/pte_divider.sv
`timescale 1ns / 1ps

module pte_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pte_pkg::div_req_t             req,
    input  logic [pte_pkg::PROD_W-1:0]    dividend,
    input  logic [pte_pkg::DATA_W-1:0]    divisor,
    output logic                          done,
    output logic [pte_pkg::PROD_W-1:0]    quot
);
    import pte_pkg::*;

    logic [DATA_W-1:0]    rem_reg;
    logic [PROD_W-1:0]    q_reg;
    logic [DATA_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DATA_W:0]      shifted;
    logic                 fits;
    logic [DATA_W-1:0]    rem_next;
    logic [PROD_W-1:0]    q_next;

    // One quotient bit per cycle, dividend bits shifted in from the top of q_reg
    always_comb
    begin
        shifted  = {rem_reg, q_reg[PROD_W-1]};
        fits     = (shifted >= {1'b0, dvs_reg});
        rem_next = fits ? DATA_W'(shifted - {1'b0, dvs_reg}) : shifted[DATA_W-1:0];
        q_next   = {q_reg[PROD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= req.steps;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### src/progress_time_estimator_top.sv
`timescale 1ns / 1ps
// Progress time estimator.
// Input channel in_ch carries one event (func, now_ms, completed_steps) per
// transfer; every event yields exactly one transfer on out_ch with the
// expected total, elapsed and remaining time, steps held and status flags.
// Two registers (original estimate, step total) are written through
// cfg_we / cfg_index / cfg_wdata; the user must write them only while no
// event is in flight, as the block itself does not enforce it.
// Events are handled one at a time. A progress report that refreshes the
// estimate runs a 32x32 multiply, a restoring divide on the bit-serial
// divider, a sweep over the estimate history and a reciprocal multiply on
// the same multiplier for the averaging weight.
// in_ch.ready is high only while the sequencer is idle. The result sits in
// an output register, so a new event may be taken while out_ch is stalled;
// its result then waits until the previous one is transferred.
// Reset clears the sequencer, estimator and output state, sets the original
// estimate to zero and the step total to one, and drops out_ch.valid.
module progress_time_estimator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pte_pkg::DATA_W-1:0]      cfg_wdata,
    pte_in_if.sink                          in_ch,
    pte_out_if.source                       out_ch
);
    import pte_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_TU,
        S_MUL,
        S_D1GO,
        S_D1W,
        S_EST,
        S_SUM,
        S_AVG,
        S_DIV5,
        S_CLAMP,
        S_FIN,
        S_RESP
    } state_t;

    state_t state_reg;

    logic [DATA_W-1:0] orig_reg;
    logic [DATA_W-1:0] total_reg;

    logic [FUNC_W-1:0] func_reg;
    logic [DATA_W-1:0] now_reg;
    logic [DATA_W-1:0] done_reg;

    logic [DATA_W-1:0] start_tick_reg;
    logic              started_reg;
    logic              ended_reg;
    logic [DATA_W-1:0] elapsed_reg;
    logic [DATA_W-1:0] expected_reg;
    logic [DATA_W-1:0] completed_reg;
    logic [DATA_W-1:0] prev_completed_reg;
    logic [DATA_W-1:0] count_reg;
    logic [DATA_W-1:0] first_el_reg;
    logic [DATA_W-1:0] first_steps_reg;
    logic [DATA_W-1:0] hist_reg [HIST_DEPTH];

    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [HIST_AW-1:0] idx_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_exp_reg;
    logic [DATA_W-1:0] out_el_reg;
    logic [DATA_W-1:0] out_rem_reg;
    logic [DATA_W-1:0] out_steps_reg;
    logic              out_run_reg;
    logic              out_fin_reg;

    logic [DATA_W-1:0]  tot;
    logic [DATA_W-1:0]  done_in;
    logic [DATA_W-1:0]  clamp_c;
    logic [DATA_W-1:0]  el_now;
    logic [HIST_AW-1:0] slot;
    logic [DATA_W-1:0]  mul_a;
    logic [DATA_W-1:0]  mul_b;
    logic [PROD_W-1:0]  prod_c;
    logic [PROD_W:0]    est_sum;
    logic [DATA_W-1:0]  est_sat;
    logic [DATA_W:0]    avg_m;
    logic [SUM_W-DATA_W:0] avg_hi;
    logic [DATA_W-1:0]  avg_q;
    logic               resp_take;

    div_req_t           div_req;
    logic [PROD_W-1:0]  div_dividend;
    logic [DATA_W-1:0]  div_divisor;
    logic               div_done;
    logic [PROD_W-1:0]  div_quot;

    always_comb
    begin
        tot     = (total_reg == '0) ? DATA_W'(1) : total_reg;
        done_in = (func_reg == FUNC_END) ? tot : done_reg;
        clamp_c = (done_in >= tot) ? tot : done_in;
        el_now  = now_reg - start_tick_reg;
        slot    = count_reg[HIST_AW-1:0];

        avg_m  = {1'b0, acc_reg[DATA_W-1:0]} + (DATA_W + 1)'(acc_reg[SUM_W-1:DATA_W]);
        avg_hi = (SUM_W - DATA_W + 1)'(acc_reg[SUM_W-1:DATA_W]) +
                 (SUM_W - DATA_W + 1)'(avg_m[DATA_W]);
        avg_q  = DATA_W'(avg_hi) * AVG_WRAP_Q + DATA_W'(prod_reg >> AVG_SHIFT);

        // Share the multiplier between the extrapolation and the averaging step
        if (state_reg == S_AVG)
        begin
            mul_a = avg_m[DATA_W-1:0];
            mul_b = AVG_RECIP;
        end
        else
        begin
            mul_a = elapsed_reg - first_el_reg;
            mul_b = tot - first_steps_reg;
        end
        prod_c  = PROD_W'(mul_a) * PROD_W'(mul_b);
        est_sum = {1'b0, div_quot} + (PROD_W + 1)'(first_el_reg);
        est_sat = (|est_sum[PROD_W:DATA_W]) ? '1 : est_sum[DATA_W-1:0];

        div_req.start = (state_reg == S_D1GO);
        div_req.steps = DIV_CNT_W'(PROD_W);
        div_dividend  = prod_reg;
        div_divisor   = completed_reg - first_steps_reg;

        resp_take = (state_reg == S_RESP) && (!out_valid_reg || out_ch.ready);
    end

    pte_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orig_reg  <= '0;
            total_reg <= DATA_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ORIG_EST)
                orig_reg <= cfg_wdata;
            else if (cfg_index == REG_TOTAL_STEPS)
                total_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            func_reg <= in_ch.func;
            now_reg  <= in_ch.now_ms;
            done_reg <= in_ch.completed_steps;
        end
        if (state_reg == S_MUL || state_reg == S_AVG)
            prod_reg <= prod_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            start_tick_reg     <= '0;
            started_reg        <= 1'b0;
            ended_reg          <= 1'b0;
            elapsed_reg        <= '0;
            expected_reg       <= '0;
            completed_reg      <= '0;
            prev_completed_reg <= '0;
            count_reg          <= '0;
            first_el_reg       <= '0;
            first_steps_reg    <= '0;
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_reg[i] <= '0;
            acc_reg            <= '0;
            idx_reg            <= '0;
            out_valid_reg      <= 1'b0;
            out_exp_reg        <= '0;
            out_el_reg         <= '0;
            out_rem_reg        <= '0;
            out_steps_reg      <= '0;
            out_run_reg        <= 1'b0;
            out_fin_reg        <= 1'b0;
        end
        else
        begin
            if (resp_take)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                        state_reg <= S_EXEC;
                end

                S_EXEC:
                begin
                    case (func_reg)
                        FUNC_INIT:
                        begin
                            start_tick_reg     <= '0;
                            started_reg        <= 1'b0;
                            ended_reg          <= 1'b0;
                            elapsed_reg        <= '0;
                            expected_reg       <= orig_reg;
                            completed_reg      <= '0;
                            prev_completed_reg <= '0;
                            count_reg          <= '0;
                            first_el_reg       <= '0;
                            first_steps_reg    <= '0;
                            for (int i = 0; i < HIST_DEPTH; i++)
                                hist_reg[i] <= orig_reg;
                            state_reg <= S_RESP;
                        end
                        FUNC_START:
                        begin
                            if (!started_reg)
                            begin
                                start_tick_reg <= now_reg;
                                started_reg    <= 1'b1;
                            end
                            state_reg <= S_RESP;
                        end
                        FUNC_PROGRESS, FUNC_END:
                        begin
                            if (func_reg == FUNC_PROGRESS || (started_reg && !ended_reg))
                            begin
                                prev_completed_reg <= completed_reg;
                                completed_reg      <= clamp_c;
                                if (clamp_c != '0)
                                begin
                                    if (count_reg == '0)
                                    begin
                                        first_el_reg    <= el_now;
                                        first_steps_reg <= clamp_c;
                                    end
                                    count_reg <= count_reg + DATA_W'(1);
                                end
                                state_reg <= S_TU;
                            end
                            else
                            begin
                                state_reg <= S_RESP;
                            end
                        end
                        FUNC_TIME:
                        begin
                            state_reg <= S_TU;
                        end
                        default:
                        begin
                            state_reg <= S_RESP;
                        end
                    endcase
                end

                S_TU:
                begin
                    if (!started_reg || ended_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        elapsed_reg <= el_now;
                        if (completed_reg == tot)
                        begin
                            expected_reg <= el_now;
                            state_reg    <= S_CLAMP;
                        end
                        else if (completed_reg == first_steps_reg ||
                                 completed_reg == prev_completed_reg ||
                                 count_reg <= DATA_W'(2))
                        begin
                            state_reg <= S_CLAMP;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end

                S_MUL:
                begin
                    state_reg <= S_D1GO;
                end

                S_D1GO:
                begin
                    state_reg <= S_D1W;
                end

                S_D1W:
                begin
                    if (div_done)
                        state_reg <= S_EST;
                end

                S_EST:
                begin
                    // Doubled weight: seed the sum with the new estimate once
                    hist_reg[slot] <= est_sat;
                    acc_reg        <= SUM_W'(est_sat);
                    idx_reg        <= '0;
                    state_reg      <= S_SUM;
                end

                S_SUM:
                begin
                    acc_reg <= acc_reg + SUM_W'(hist_reg[idx_reg]);
                    idx_reg <= idx_reg + HIST_AW'(1);
                    if (idx_reg == HIST_AW'(HIST_DEPTH - 1))
                        state_reg <= S_AVG;
                end

                S_AVG:
                begin
                    state_reg <= S_DIV5;
                end

                S_DIV5:
                begin
                    hist_reg[slot] <= avg_q;
                    expected_reg   <= avg_q;
                    state_reg      <= S_CLAMP;
                end

                S_CLAMP:
                begin
                    // The estimate never drops below elapsed time
                    if (elapsed_reg >= expected_reg)
                        expected_reg <= elapsed_reg;
                    state_reg <= S_FIN;
                end

                S_FIN:
                begin
                    if (func_reg != FUNC_TIME && completed_reg == tot)
                        ended_reg <= 1'b1;
                    state_reg <= S_RESP;
                end

                S_RESP:
                begin
                    // Hold until the output register is free
                    if (resp_take)
                    begin
                        out_exp_reg   <= expected_reg;
                        out_el_reg    <= elapsed_reg;
                        out_rem_reg   <= expected_reg - elapsed_reg;
                        out_steps_reg <= completed_reg;
                        out_run_reg   <= started_reg && !ended_reg;
                        out_fin_reg   <= ended_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready              = (state_reg == S_IDLE);
    assign out_ch.valid             = out_valid_reg;
    assign out_ch.expected_total_ms = out_exp_reg;
    assign out_ch.elapsed_ms        = out_el_reg;
    assign out_ch.remaining_ms      = out_rem_reg;
    assign out_ch.steps_done        = out_steps_reg;
    assign out_ch.running           = out_run_reg;
    assign out_ch.finished          = out_fin_reg;

endmodule

### verif/tb_progress_time_estimator_top.sv
`timescale 1ns / 1ps

module tb_progress_time_estimator_top;
    import pte_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] total;
        logic [DATA_W-1:0] elapsed;
        logic [DATA_W-1:0] remaining;
        logic [DATA_W-1:0] steps;
        logic              running;
        logic              finished;
    } estimate_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_wdata;

    pte_in_if  in_ch ();
    pte_out_if out_ch ();

    progress_time_estimator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Estimator shadow: registers and state
    logic [DATA_W-1:0] cfg_estimate;
    logic [DATA_W-1:0] cfg_steps;
    logic [DATA_W-1:0] t0_tick;
    logic              is_started;
    logic              is_ended;
    logic [DATA_W-1:0] elapsed_now;
    logic [DATA_W-1:0] total_estimate;
    logic [DATA_W-1:0] steps_held;
    logic [DATA_W-1:0] steps_before;
    logic [DATA_W-1:0] nonzero_reports;
    logic [DATA_W-1:0] anchor_elapsed;
    logic [DATA_W-1:0] anchor_steps;
    logic [DATA_W-1:0] history [HIST_DEPTH];

    estimate_t pending_estimates [$];

    int fault_count;
    int sent_count;
    int send_gap_pct;
    int recv_stall_pct;
    int outage_request;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("tb_progress_time_estimator_top NOT OK");
        $finish;
    end

    function automatic logic [DATA_W-1:0] effective_steps();
        return (cfg_steps != '0) ? cfg_steps : DATA_W'(1);
    endfunction

    function automatic void clear_estimator();
        t0_tick         = '0;
        is_started      = 1'b0;
        is_ended        = 1'b0;
        elapsed_now     = '0;
        total_estimate  = cfg_estimate;
        steps_held      = '0;
        steps_before    = '0;
        nonzero_reports = '0;
        anchor_elapsed  = '0;
        anchor_steps    = '0;
        foreach (history[i])
            history[i] = cfg_estimate;
    endfunction

    function automatic void advance_clock(logic [DATA_W-1:0] now);
        logic [DATA_W-1:0] tot;
        logic [DATA_W-1:0] time_span;
        logic [DATA_W-1:0] step_left;
        logic [DATA_W-1:0] step_gain;
        logic [PROD_W-1:0] linear;
        logic [PROD_W-1:0] blend;
        logic [HIST_AW-1:0] slot;
        tot = effective_steps();
        if (!is_started || is_ended)
            return;
        elapsed_now = now - t0_tick;
        if (steps_held == tot)
            total_estimate = elapsed_now;
        else if (steps_held != anchor_steps && steps_held != steps_before
                 && nonzero_reports > 2)
        begin
            // Extrapolate linearly from the first nonzero report
            time_span = elapsed_now - anchor_elapsed;
            step_left = tot - anchor_steps;
            step_gain = steps_held - anchor_steps;
            linear = PROD_W'(time_span) * PROD_W'(step_left);
            linear = linear / PROD_W'(step_gain) + PROD_W'(anchor_elapsed);
            slot = nonzero_reports[HIST_AW-1:0];
            history[slot] = (linear[PROD_W-1:DATA_W] != '0) ? {DATA_W{1'b1}}
                                                             : linear[DATA_W-1:0];
            // The newest entry counts twice
            blend = PROD_W'(history[slot]);
            foreach (history[i])
                blend += PROD_W'(history[i]);
            blend = blend / PROD_W'(HIST_DEPTH + 1);
            history[slot] = blend[DATA_W-1:0];
            total_estimate = blend[DATA_W-1:0];
        end
        if (elapsed_now >= total_estimate)
            total_estimate = elapsed_now;
    endfunction

    function automatic void log_progress(logic [DATA_W-1:0] done, logic [DATA_W-1:0] now);
        logic [DATA_W-1:0] tot;
        logic [DATA_W-1:0] clamped;
        tot = effective_steps();
        clamped = (done >= tot) ? tot : done;
        steps_before = steps_held;
        steps_held = clamped;
        if (clamped != '0)
        begin
            if (nonzero_reports == '0)
            begin
                anchor_elapsed = now - t0_tick;
                anchor_steps = clamped;
            end
            nonzero_reports++;
        end
        advance_clock(now);
        if (steps_held == tot)
            is_ended = 1'b1;
    endfunction

    function automatic estimate_t predict_event(logic [FUNC_W-1:0] func,
                                                logic [DATA_W-1:0] now,
                                                logic [DATA_W-1:0] done);
        estimate_t r;
        case (func)
            FUNC_INIT:
                clear_estimator();
            FUNC_START:
                if (!is_started)
                begin
                    t0_tick = now;
                    is_started = 1'b1;
                end
            FUNC_PROGRESS:
                log_progress(done, now);
            FUNC_END:
                if (is_started && !is_ended)
                    log_progress(effective_steps(), now);
            FUNC_TIME:
                advance_clock(now);
            default:
                ;
        endcase
        r.total     = total_estimate;
        r.elapsed   = elapsed_now;
        r.remaining = total_estimate - elapsed_now;
        r.steps     = steps_held;
        r.running   = is_started && !is_ended;
        r.finished  = is_ended;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (fault_count < 40)
            $display("ERROR @%0t: %s", $time, msg);
        fault_count++;
    endtask

    task automatic send_event(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] now,
                              logic [DATA_W-1:0] done);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_ch.valid           <= 1'b0;
            in_ch.func            <= FUNC_W'($urandom);
            in_ch.now_ms          <= $urandom;
            in_ch.completed_steps <= $urandom;
            @(negedge clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.func            <= func;
        in_ch.now_ms          <= now;
        in_ch.completed_steps <= done;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_estimates.push_back(predict_event(func, now, done));
        sent_count++;
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_drained(int extra);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_ORIG_EST)
            cfg_estimate = value;
        else
            cfg_steps = value;
    endtask

    task automatic pick_registers();
        logic [DATA_W-1:0] est;
        logic [DATA_W-1:0] steps;
        case ($urandom_range(3))
            0: est = '0;
            1: est = '1;
            2: est = $urandom;
            default: est = $urandom_range(100, 100000);
        endcase
        case ($urandom_range(7))
            0: steps = '0;
            1: steps = '1;
            2: steps = $urandom;
            default: steps = $urandom_range(2, 40);
        endcase
        write_reg(REG_ORIG_EST, est);
        write_reg(REG_TOTAL_STEPS, steps);
    endtask

    // One task run from init to a closing event, with random content and some noise
    task automatic run_session();
        logic [DATA_W-1:0] clock_ms;
        logic [DATA_W-1:0] done;
        logic [DATA_W-1:0] tot;
        logic [DATA_W-1:0] stride;
        int reports;
        if ($urandom_range(5) == 0)
        begin
            wait_drained(4);
            pick_registers();
        end
        send_event(FUNC_INIT, $urandom, $urandom);
        clock_ms = $urandom;
        send_event(FUNC_START, clock_ms, $urandom);
        tot = effective_steps();
        done = '0;
        reports = $urandom_range(3, 12);
        repeat (reports)
        begin
            clock_ms += ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 2000);
            case ($urandom_range(19))
                0: send_event(FUNC_W'($urandom), $urandom, $urandom);
                1, 2: send_event(FUNC_TIME, clock_ms, $urandom);
                3: send_event(FUNC_PROGRESS, clock_ms, $urandom);
                4:
                begin
                    // Change the step total while running
                    wait_drained(4);
                    write_reg(REG_TOTAL_STEPS, $urandom_range(1, 64));
                    tot = effective_steps();
                    if (done > tot)
                        done = tot;
                    send_event(FUNC_TIME, clock_ms, $urandom);
                end
                default:
                begin
                    stride = (tot <= 64) ? $urandom_range(0, 2) : $urandom_range(0, tot >> 3);
                    done = (tot - done > stride) ? done + stride : tot;
                    send_event(FUNC_PROGRESS, clock_ms, done);
                end
            endcase
        end
        clock_ms += $urandom_range(1, 5000);
        case ($urandom_range(3))
            0: send_event(FUNC_TIME, clock_ms, $urandom);
            1: send_event(FUNC_PROGRESS, clock_ms, tot);
            default: send_event(FUNC_END, clock_ms, $urandom);
        endcase
        if ($urandom_range(3) == 0)
            send_event(FUNC_W'($urandom_range(FUNC_START, FUNC_TIME)), $urandom, $urandom);
    endtask

    task automatic test_events_before_start();
        for (int f = FUNC_TIME + 1; f < (1 << FUNC_W); f++)
            send_event(FUNC_W'(f), $urandom, $urandom);
        send_event(FUNC_TIME, 32'd123, '0);
        send_event(FUNC_END, 32'd200, '0);
        send_event(FUNC_PROGRESS, 32'd300, '0);
        send_event(FUNC_PROGRESS, 32'd400, '1);
        send_event(FUNC_START, 32'd500, '0);
        send_event(FUNC_INIT, '1, '1);
    endtask

    task automatic test_register_extremes();
        wait_drained(4);
        write_reg(REG_ORIG_EST, '1);
        write_reg(REG_TOTAL_STEPS, '0);
        send_event(FUNC_INIT, '0, '0);
        send_event(FUNC_START, '0, '0);
        send_event(FUNC_PROGRESS, 32'd5, '0);
        send_event(FUNC_START, 32'd9, '0);
        send_event(FUNC_TIME, '1, '0);
        send_event(FUNC_END, '1, '0);
    endtask

    task automatic test_estimate_saturation();
        wait_drained(4);
        write_reg(REG_ORIG_EST, '0);
        write_reg(REG_TOTAL_STEPS, '1);
        send_event(FUNC_INIT, '0, '0);
        // Start close to the wrap of the tick counter
        send_event(FUNC_START, 32'hFFFF_FFF0, '0);
        send_event(FUNC_PROGRESS, 32'hFFFF_FFF0 + 32'd1000, 32'd1);
        send_event(FUNC_TIME, 32'hFFFF_FFF0 + 32'd1500, '0);
        send_event(FUNC_PROGRESS, 32'hFFFF_FFF0 + 32'd2000, 32'd2);
        send_event(FUNC_PROGRESS, 32'h7FFF_FFF0, 32'd3);
        send_event(FUNC_PROGRESS, 32'h8FFF_FFF0, '1);
        send_event(FUNC_TIME, 32'h9FFF_FFF0, '0);
        send_event(FUNC_PROGRESS, 32'hAFFF_FFF0, 32'd7);
        send_event(FUNC_END, 32'hBFFF_FFF0, '0);
    endtask

    task automatic test_steps_change_while_running();
        wait_drained(4);
        write_reg(REG_ORIG_EST, 32'd5000);
        write_reg(REG_TOTAL_STEPS, 32'd10);
        send_event(FUNC_INIT, '0, '0);
        send_event(FUNC_START, 32'd100, '0);
        send_event(FUNC_PROGRESS, 32'd1100, 32'd2);
        send_event(FUNC_PROGRESS, 32'd2100, 32'd4);
        send_event(FUNC_PROGRESS, 32'd3100, 32'd6);
        wait_drained(4);
        write_reg(REG_TOTAL_STEPS, 32'd8);
        send_event(FUNC_PROGRESS, 32'd3600, 32'd7);
        send_event(FUNC_TIME, 32'd4000, '0);
        send_event(FUNC_END, 32'd4200, '0);
    endtask

    task automatic test_random_traffic(int gap_pct, int stall_pct, int item_goal,
                                       int outage_cycles);
        int goal;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        outage_request = outage_cycles;
        goal = sent_count + item_goal;
        while (sent_count < goal)
            run_session();
    endtask

    // Receiver: random stalls plus an occasional long outage
    initial
    begin
        int outage_left;
        outage_left  = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (outage_request > 0)
            begin
                outage_left = outage_request;
                outage_request = 0;
            end
            if (outage_left > 0)
            begin
                out_ch.ready <= 1'b0;
                outage_left--;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        estimate_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_estimates.size() == 0)
                report_mismatch("result transfer with nothing pending");
            else
            begin
                want = pending_estimates.pop_front();
                if (out_ch.expected_total_ms !== want.total)
                    report_mismatch($sformatf("expected_total_ms got %0h want %0h",
                                              out_ch.expected_total_ms, want.total));
                if (out_ch.elapsed_ms !== want.elapsed)
                    report_mismatch($sformatf("elapsed_ms got %0h want %0h",
                                              out_ch.elapsed_ms, want.elapsed));
                if (out_ch.remaining_ms !== want.remaining)
                    report_mismatch($sformatf("remaining_ms got %0h want %0h",
                                              out_ch.remaining_ms, want.remaining));
                if (out_ch.steps_done !== want.steps)
                    report_mismatch($sformatf("steps_done got %0h want %0h",
                                              out_ch.steps_done, want.steps));
                if (out_ch.running !== want.running)
                    report_mismatch($sformatf("running got %b want %b",
                                              out_ch.running, want.running));
                if (out_ch.finished !== want.finished)
                    report_mismatch($sformatf("finished got %b want %b",
                                              out_ch.finished, want.finished));
            end
        end
    end

    initial
    begin
        int waited;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_wdata             = '0;
        in_ch.valid           = 1'b0;
        in_ch.func            = '0;
        in_ch.now_ms          = '0;
        in_ch.completed_steps = '0;
        fault_count           = 0;
        sent_count            = 0;
        send_gap_pct          = 12;
        recv_stall_pct        = 62;
        outage_request        = 0;
        cfg_estimate          = '0;
        cfg_steps             = DATA_W'(1);
        clear_estimator();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_events_before_start();
        test_register_extremes();
        test_estimate_saturation();
        test_steps_change_while_running();
        test_random_traffic(12, 62, 270, 400);
        test_random_traffic(62, 12, 270, 0);
        test_random_traffic(0, 0, 270, 0);

        @(negedge clk);
        in_ch.valid <= 1'b0;
        waited = 0;
        while (pending_estimates.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (200) @(posedge clk);
        if (pending_estimates.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_estimates.size()));
        if (fault_count == 0)
            $display("tb_progress_time_estimator_top OK");
        else
            $display("tb_progress_time_estimator_top NOT OK");
        $finish;
    end

endmodule

### progress_time_estimator_top.f
src/pte_pkg.sv
src/pte_if.sv
src/pte_divider.sv
src/progress_time_estimator_top.sv
verif/tb_progress_time_estimator_top.sv
